FILE: rtl/two_region_page_bitmap_allocator_top_defines.svh
// Assertion helpers shared by the allocator modules.
`ifndef TWO_REGION_PAGE_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define TWO_REGION_PAGE_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define TPBA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while in reset.
`define TPBA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tpba_pkg.sv
package tpba_pkg;

  localparam int CRITICAL_PAGES_DEF = 1024;
  localparam int GENERAL_PAGES_DEF  = 8192;
  localparam int PAGE_SHIFT_DEF     = 12;

  localparam int ADDR_W  = 48;
  localparam int COUNT_W = 16;
  localparam int WORD_W  = 64;

  localparam logic [1:0] REQ_ALLOC_CRIT = 2'd0;
  localparam logic [1:0] REQ_ALLOC_GEN  = 2'd1;
  localparam logic [1:0] REQ_RESERVE    = 2'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_MISALIGNED = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ALLOC,
    RES_NO_FREE,
    RES_MISALIGNED,
    RES_RANGE
  } res_sel_t;

  typedef struct packed {
    logic     clr_en;
    logic     load;
    logic     scan_step;
    logic     alloc_commit;
    logic     rsv_issue;
    logic     rsv_write;
    logic     res_we;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic found;
    logic last_word;
    logic misaligned;
    logic rsv_zero;
    logic rsv_beyond;
  } sts_t;

endpackage

FILE: rtl/two_region_page_bitmap_allocator_top.sv
// Page allocator over two bitmaps (critical region at low addresses, general region above
// it), each held in a 64-bit-wide RAM. After reset a clearing pass zeroes both maps of
// CW and GW words (region pages / 64, rounded up) with busy high. A request is
// taken when start is high and busy is low; its result appears on status and page_address
// for exactly one cycle with done high, and must be captured then: there is no stall.
// An allocation reads one bitmap word per cycle from the region RAM and scans at most
// CW or GW words until done. A reserve handles one 64-page word at a time (registered
// RAM read, then the write of the merged word); a misaligned reserve or an unused
// request type gives its result in the cycle after it is taken. A new request may be
// issued in the same cycle that done is high.
module two_region_page_bitmap_allocator_top #(
  parameter int CRITICAL_PAGES = tpba_pkg::CRITICAL_PAGES_DEF,
  parameter int GENERAL_PAGES  = tpba_pkg::GENERAL_PAGES_DEF,
  parameter int PAGE_SHIFT     = tpba_pkg::PAGE_SHIFT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type,
  input  logic [tpba_pkg::ADDR_W-1:0]  start_address,
  input  logic [tpba_pkg::COUNT_W-1:0] page_count,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [tpba_pkg::ADDR_W-1:0]  page_address
);

  tpba_pkg::cmd_t cmd;
  tpba_pkg::sts_t sts;

  tpba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_type(req_type),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  tpba_datapath #(
    .CRITICAL_PAGES(CRITICAL_PAGES),
    .GENERAL_PAGES (GENERAL_PAGES),
    .PAGE_SHIFT    (PAGE_SHIFT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req_type     (req_type),
    .start_address(start_address),
    .page_count   (page_count),
    .cmd          (cmd),
    .sts          (sts),
    .status       (status),
    .page_address (page_address)
  );

endmodule

FILE: rtl/tpba_ram.sv
module tpba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tpba_datapath.sv
`include "two_region_page_bitmap_allocator_top_defines.svh"

module tpba_datapath #(
  parameter int CRITICAL_PAGES = tpba_pkg::CRITICAL_PAGES_DEF,
  parameter int GENERAL_PAGES  = tpba_pkg::GENERAL_PAGES_DEF,
  parameter int PAGE_SHIFT     = tpba_pkg::PAGE_SHIFT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   req_type,
  input  logic [tpba_pkg::ADDR_W-1:0]  start_address,
  input  logic [tpba_pkg::COUNT_W-1:0] page_count,
  input  tpba_pkg::cmd_t               cmd,
  output tpba_pkg::sts_t               sts,
  output logic [1:0]                   status,
  output logic [tpba_pkg::ADDR_W-1:0]  page_address
);

  localparam int AW     = tpba_pkg::ADDR_W;
  localparam int WW     = tpba_pkg::WORD_W;
  localparam int CW     = (CRITICAL_PAGES + WW - 1) / WW;
  localparam int GW     = (GENERAL_PAGES + WW - 1) / WW;
  localparam int MW     = (CW > GW) ? CW : GW;
  localparam int CAW    = (CW > 1) ? $clog2(CW) : 1;
  localparam int GAW    = (GW > 1) ? $clog2(GW) : 1;
  localparam int WAW    = (MW > 1) ? $clog2(MW) : 1;
  localparam int PW     = AW - PAGE_SHIFT + 1;
  localparam int MAXP   = (CRITICAL_PAGES > GENERAL_PAGES) ? CRITICAL_PAGES : GENERAL_PAGES;
  localparam int LW     = $clog2(MAXP) + 1;
  localparam int TOTAL  = CRITICAL_PAGES + GENERAL_PAGES;
  localparam int CREM   = CRITICAL_PAGES % WW;
  localparam int GREM   = GENERAL_PAGES % WW;
  localparam logic [WW-1:0] CLAST_INVAL =
    (CREM == 0) ? '0 : ~((64'd1 << CREM) - 64'd1);
  localparam logic [WW-1:0] GLAST_INVAL =
    (GREM == 0) ? '0 : ~((64'd1 << GREM) - 64'd1);

  logic [WAW-1:0]   clr_idx;
  logic [WAW-1:0]   scan_w;
  logic             region_gen;
  logic [PW-1:0]    page;
  logic [15:0]      cnt;
  logic             rsv_crit;
  logic [WAW-1:0]   rsv_word;
  logic [WW-1:0]    rsv_mask;
  logic [6:0]       rsv_n;
  tpba_pkg::status_t res_status;
  logic [AW-1:0]    res_addr;

  logic [WAW-1:0]   scan_raddr;
  logic [WW-1:0]    crit_rdata;
  logic [WW-1:0]    gen_rdata;
  logic [WW-1:0]    word_data;
  logic [WW-1:0]    occ;
  logic [WW-1:0]    free_bits;
  logic [WW-1:0]    onehot;
  logic [5:0]       bit_idx;
  logic [AW-1:0]    alloc_addr;

  logic             in_crit;
  logic [LW-1:0]    local_page;
  logic [LW:0]      reg_left;
  logic [5:0]       lo;
  logic [6:0]       room;
  logic [6:0]       n_calc;
  logic [6:0]       hi;
  logic [WW-1:0]    hi_mask;
  logic [WW-1:0]    lo_mask;
  logic [WAW-1:0]   word_calc;

  logic             crit_we;
  logic             gen_we;
  logic [WAW-1:0]   waddr;
  logic [WW-1:0]    wdata;
  logic             clr_crit_ok;
  logic             clr_gen_ok;

  assign scan_raddr = cmd.load ? '0 : (cmd.scan_step ? scan_w + WAW'(1) : scan_w);

  assign word_data = region_gen ? gen_rdata : crit_rdata;

  always_comb begin
    occ = word_data;
    if (scan_w == '0) begin
      occ[0] = 1'b1;
    end
    if (!region_gen && scan_w == WAW'(CW - 1)) begin
      occ = occ | CLAST_INVAL;
    end
    if (region_gen && scan_w == WAW'(GW - 1)) begin
      occ = occ | GLAST_INVAL;
    end
  end

  assign free_bits = ~occ;
  assign onehot    = free_bits & (~free_bits + 64'd1);

  always_comb begin
    bit_idx = '0;
    for (int b = 0; b < WW; b++) begin
      if (onehot[b]) begin
        bit_idx = bit_idx | 6'(b);
      end
    end
  end

  assign alloc_addr = (AW'({scan_w, bit_idx}) +
                       (region_gen ? AW'(CRITICAL_PAGES) : AW'(0))) << PAGE_SHIFT;

  assign in_crit    = page < PW'(CRITICAL_PAGES);
  assign local_page = in_crit ? LW'(page) : LW'(page - PW'(CRITICAL_PAGES));
  assign reg_left   = (in_crit ? (LW + 1)'(CRITICAL_PAGES) : (LW + 1)'(GENERAL_PAGES)) -
                      {1'b0, local_page};
  assign lo         = local_page[5:0];
  assign room       = 7'd64 - {1'b0, lo};
  assign word_calc  = WAW'(local_page >> 6);

  always_comb begin
    n_calc = room;
    if (cnt < 16'(n_calc)) begin
      n_calc = cnt[6:0];
    end
    if (reg_left < (LW + 1)'(n_calc)) begin
      n_calc = reg_left[6:0];
    end
  end

  assign hi      = {1'b0, lo} + n_calc;
  assign hi_mask = hi[6] ? '1 : ((64'd1 << hi[5:0]) - 64'd1);
  assign lo_mask = (64'd1 << lo) - 64'd1;

  assign clr_crit_ok = {1'b0, clr_idx} < (WAW + 1)'(CW);
  assign clr_gen_ok  = {1'b0, clr_idx} < (WAW + 1)'(GW);

  always_comb begin
    crit_we = 1'b0;
    gen_we  = 1'b0;
    waddr   = rsv_word;
    wdata   = (rsv_crit ? crit_rdata : gen_rdata) | rsv_mask;
    if (cmd.clr_en) begin
      crit_we = clr_crit_ok;
      gen_we  = clr_gen_ok;
      waddr   = clr_idx;
      wdata   = '0;
    end else if (cmd.alloc_commit) begin
      crit_we = !region_gen;
      gen_we  = region_gen;
      waddr   = scan_w;
      wdata   = word_data | onehot;
    end else if (cmd.rsv_write) begin
      crit_we = rsv_crit;
      gen_we  = !rsv_crit;
    end
  end

  tpba_ram #(
    .WIDTH(WW),
    .DEPTH(CW)
  ) u_crit_ram (
    .clk  (clk),
    .we   (crit_we),
    .waddr(waddr[CAW-1:0]),
    .wdata(wdata),
    .raddr(cmd.rsv_issue ? word_calc[CAW-1:0] : scan_raddr[CAW-1:0]),
    .rdata(crit_rdata)
  );

  tpba_ram #(
    .WIDTH(WW),
    .DEPTH(GW)
  ) u_gen_ram (
    .clk  (clk),
    .we   (gen_we),
    .waddr(waddr[GAW-1:0]),
    .wdata(wdata),
    .raddr(cmd.rsv_issue ? word_calc[GAW-1:0] : scan_raddr[GAW-1:0]),
    .rdata(gen_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_en) begin
      clr_idx <= clr_idx + WAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_w     <= '0;
      region_gen <= (req_type == tpba_pkg::REQ_ALLOC_GEN);
      page       <= PW'(start_address >> PAGE_SHIFT);
      cnt        <= page_count;
    end else if (cmd.scan_step) begin
      scan_w <= scan_w + WAW'(1);
    end
    if (cmd.rsv_issue) begin
      rsv_crit <= in_crit;
      rsv_word <= word_calc;
      rsv_mask <= hi_mask & ~lo_mask;
      rsv_n    <= n_calc;
    end
    if (cmd.rsv_write) begin
      page <= page + PW'(rsv_n);
      cnt  <= cnt - 16'(rsv_n);
    end
    if (cmd.res_we) begin
      case (cmd.res_sel)
        tpba_pkg::RES_ALLOC: begin
          res_status <= tpba_pkg::ST_OK;
          res_addr   <= alloc_addr;
        end
        tpba_pkg::RES_NO_FREE: begin
          res_status <= tpba_pkg::ST_NO_FREE;
          res_addr   <= '0;
        end
        tpba_pkg::RES_MISALIGNED: begin
          res_status <= tpba_pkg::ST_MISALIGNED;
          res_addr   <= '0;
        end
        tpba_pkg::RES_RANGE: begin
          res_status <= tpba_pkg::ST_RANGE;
          res_addr   <= '0;
        end
        default: begin
          res_status <= tpba_pkg::ST_OK;
          res_addr   <= '0;
        end
      endcase
    end
  end

  assign sts.clr_last   = clr_idx == WAW'(MW - 1);
  assign sts.found      = |free_bits;
  assign sts.last_word  = region_gen ? (scan_w == WAW'(GW - 1)) : (scan_w == WAW'(CW - 1));
  assign sts.misaligned = |(start_address & ((AW'(1) << PAGE_SHIFT) - AW'(1)));
  assign sts.rsv_zero   = cnt == '0;
  assign sts.rsv_beyond = page >= PW'(TOTAL);

  assign status       = res_status;
  assign page_address = res_addr;

  `TPBA_ASSERT_IMP(a_alloc_one_bit, clk, rst, cmd.alloc_commit, $countones(wdata) == $countones(word_data) + 1, "allocation must set exactly one new bit")
  `TPBA_ASSERT_IMP(a_rsv_progress, clk, rst, cmd.rsv_issue, n_calc != 7'd0 && (hi_mask & ~lo_mask) != '0, "reserve step must cover at least one page")
  `TPBA_ASSERT_NXT(a_rsv_in_range, clk, rst, cmd.rsv_issue, {1'b0, rsv_word} < (WAW + 1)'(rsv_crit ? CW : GW), "reserve word outside its region")

endmodule

FILE: rtl/tpba_ctrl.sv
`include "two_region_page_bitmap_allocator_top_defines.svh"

module tpba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     req_type,
  input  tpba_pkg::sts_t sts,
  output tpba_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_RSV_RD,
    S_RSV_WR
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd         = '0;
    cmd.res_sel = tpba_pkg::RES_NONE;
    state_next  = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (req_type)
            tpba_pkg::REQ_ALLOC_CRIT, tpba_pkg::REQ_ALLOC_GEN: begin
              state_next = S_ALLOC;
            end
            tpba_pkg::REQ_RESERVE: begin
              if (sts.misaligned) begin
                cmd.res_we  = 1'b1;
                cmd.res_sel = tpba_pkg::RES_MISALIGNED;
              end else begin
                state_next = S_RSV_RD;
              end
            end
            default: begin
              cmd.res_we  = 1'b1;
              cmd.res_sel = tpba_pkg::RES_NONE;
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (sts.found) begin
          cmd.alloc_commit = 1'b1;
          cmd.res_we       = 1'b1;
          cmd.res_sel      = tpba_pkg::RES_ALLOC;
          state_next       = S_IDLE;
        end else if (sts.last_word) begin
          cmd.res_we  = 1'b1;
          cmd.res_sel = tpba_pkg::RES_NO_FREE;
          state_next  = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RSV_RD: begin
        if (sts.rsv_zero) begin
          cmd.res_we  = 1'b1;
          cmd.res_sel = tpba_pkg::RES_NONE;
          state_next  = S_IDLE;
        end else if (sts.rsv_beyond) begin
          cmd.res_we  = 1'b1;
          cmd.res_sel = tpba_pkg::RES_RANGE;
          state_next  = S_IDLE;
        end else begin
          cmd.rsv_issue = 1'b1;
          state_next    = S_RSV_WR;
        end
      end
      S_RSV_WR: begin
        cmd.rsv_write = 1'b1;
        state_next    = S_RSV_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.res_we;
    end
  end

  assign busy = (state != S_IDLE);

  `TPBA_ASSERT_NXT(a_accept_progress, clk, rst, start && !busy, done || busy, "accepted beat neither finished nor in progress")
  `TPBA_ASSERT_IMP(a_fall_with_done, clk, rst, $fell(busy) && ($past(state) != S_CLEAR), done, "request ended without a result beat")
  `TPBA_ASSERT_IMP(a_no_done_in_clear, clk, rst, state == S_CLEAR, !done && !cmd.res_we, "result during clearing pass")

endmodule
